// ===== sv/pfrt_pkg.sv =====
// Shared constants, codes and cell control types for the port filter rule table.
package pfrt_pkg;

  localparam int MAX_RULES_DEF = 64;

  localparam int CMD_W     = 2;
  localparam int PORT_W    = 16;
  localparam int DEL_IDX_W = 6;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INBOUND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_OUTBOUND = 2'd3;

  localparam logic DIR_IN  = 1'b0;
  localparam logic DIR_OUT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // per-cell update controls
  typedef struct packed {
    logic load;   // take the new rule
    logic shift;  // take the neighbor's rule
    logic occ;    // cell holds a live rule
  } cell_ctl_t;

  // lookup key broadcast to every cell
  typedef struct packed {
    logic              chk;
    logic              dir;
    logic [PORT_W-1:0] port;
  } lookup_key_t;

endpackage

// ===== sv/port_filter_rule_table.sv =====
// Top level of the port filter rule table: command decode, cell row and result stage.
//
// Usage: drive in_cmd and the other in_ fields and raise start; a word is taken at
// every rising edge where start is high and busy is low. Commands: add a rule at the
// tail, delete the rule at in_del_index (younger rules move down one slot), look up an
// inbound packet by source port, or an outbound packet by destination port.
// Each word gives exactly one result word on out_drop, out_status and out_count_now,
// shown for one cycle with out_valid high, after the stage 1 and stage 2 registers.
// Throughput is one word per cycle: the row of rule cells updates and compares at the
// accept edge, and a second register stage ORs the per-cell hit bits, so busy stays
// low. The result comes through that two-level path: cell compare, then the hit reduction.
// A packet sees every add or delete taken before it.
// Reset (rst_n low, synchronous) empties the table and drops any word in flight;
// rule slots themselves are not cleared, only the rule count.
// The receiver cannot stall: a result is presented for its one cycle and then gone.
module port_filter_rule_table #(
  parameter int MAX_RULES = pfrt_pkg::MAX_RULES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pfrt_pkg::CMD_W-1:0]     in_cmd,
  input  logic                           in_rule_dir,
  input  logic [pfrt_pkg::PORT_W-1:0]    in_rule_port,
  input  logic [pfrt_pkg::DEL_IDX_W-1:0] in_del_index,
  input  logic [pfrt_pkg::PORT_W-1:0]    in_src_port,
  input  logic [pfrt_pkg::PORT_W-1:0]    in_dst_port,
  output logic                           out_valid,
  output logic                           out_drop,
  output logic [pfrt_pkg::STATUS_W-1:0]  out_status,
  output logic [pfrt_pkg::OUT_CNT_W-1:0] out_count_now
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int CMP_W = (CNT_W > pfrt_pkg::DEL_IDX_W) ? CNT_W : pfrt_pkg::DEL_IDX_W;

  logic                          accept;
  logic                          add_ok, del_ok;
  logic [CMP_W-1:0]              idx_ext, cnt_ext;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [pfrt_pkg::STATUS_W-1:0] status_nxt;
  pfrt_pkg::lookup_key_t         key;

  logic [MAX_RULES-1:0]          cell_dir;
  logic [pfrt_pkg::PORT_W-1:0]   cell_port [MAX_RULES];
  logic [MAX_RULES-1:0]          cell_hit;

  // stage 1: command done, hits latched in the cells
  logic                          s1_vld_r;
  logic [pfrt_pkg::STATUS_W-1:0] s1_status_r;
  logic [CNT_W-1:0]              s1_cnt_r;
  // stage 2: result word
  logic                          out_vld_r;
  logic                          out_drop_r;
  logic [pfrt_pkg::STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]              out_cnt_r;

  // every word is taken on arrival; the row keeps pace with one word per cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign idx_ext = CMP_W'(in_del_index);
  assign cnt_ext = CMP_W'(count_r);

  assign add_ok = accept && (in_cmd == pfrt_pkg::CMD_ADD) &&
                  (count_r != CNT_W'(MAX_RULES));
  assign del_ok = accept && (in_cmd == pfrt_pkg::CMD_DEL) && (idx_ext < cnt_ext);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = pfrt_pkg::ST_OK;
    key.chk    = 1'b0;
    key.dir    = pfrt_pkg::DIR_IN;
    key.port   = in_src_port;
    case (in_cmd)
      pfrt_pkg::CMD_ADD: begin
        if (add_ok) count_nxt = count_r + CNT_W'(1);
        else        status_nxt = pfrt_pkg::ST_FULL;
      end
      pfrt_pkg::CMD_DEL: begin
        if (del_ok) count_nxt = count_r - CNT_W'(1);
        else        status_nxt = pfrt_pkg::ST_RANGE;
      end
      pfrt_pkg::CMD_INBOUND: begin
        key.chk  = accept;
        key.dir  = pfrt_pkg::DIR_IN;
        key.port = in_src_port;
      end
      pfrt_pkg::CMD_OUTBOUND: begin
        key.chk  = accept;
        key.dir  = pfrt_pkg::DIR_OUT;
        key.port = in_dst_port;
      end
      default: begin
        key.chk = 1'b0;
      end
    endcase
  end

  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
    pfrt_pkg::cell_ctl_t          ctl;
    logic                         nbr_dir;
    logic [pfrt_pkg::PORT_W-1:0]  nbr_port;

    assign ctl.load  = add_ok && (count_r == CNT_W'(k));
    assign ctl.shift = del_ok && (CMP_W'(k) >= idx_ext);
    assign ctl.occ   = (CNT_W'(k) < count_r);

    if (k == MAX_RULES - 1) begin : g_tail
      assign nbr_dir  = 1'b0;
      assign nbr_port = '0;
    end else begin : g_mid
      assign nbr_dir  = cell_dir[k+1];
      assign nbr_port = cell_port[k+1];
    end

    pfrt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key),
      .new_dir  (in_rule_dir),
      .new_port (in_rule_port),
      .nbr_dir  (nbr_dir),
      .nbr_port (nbr_port),
      .dir      (cell_dir[k]),
      .port     (cell_port[k]),
      .hit      (cell_hit[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      s1_vld_r  <= accept;
      out_vld_r <= s1_vld_r;
    end
    s1_status_r  <= status_nxt;
    s1_cnt_r     <= count_nxt;
    // hit bits are only set for packet words
    out_drop_r   <= |cell_hit;
    out_status_r <= s1_status_r;
    out_cnt_r    <= s1_cnt_r;
  end

  assign out_valid     = out_vld_r;
  assign out_drop      = out_drop_r;
  assign out_status    = out_status_r;
  assign out_count_now = pfrt_pkg::OUT_CNT_W'(out_cnt_r);

`ifndef SYNTH
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("accepted word gave no result two cycles later");

  a_drop_only_packets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pfrt_pkg::ST_OK) |-> !out_drop)
    else $error("drop set on a failed command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RULES))
    else $error("rule count beyond table size");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && (s1_status_r != pfrt_pkg::ST_OK) && $past(rst_n) |-> $stable(count_r))
    else $error("failed command changed the rule count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("rule count moved with no word taken");
`endif

endmodule

// ===== sv/pfrt_cell.sv =====
// One rule slot: holds a direction and port, shifts from its neighbor, compares against a key.
module pfrt_cell (
  input  logic                        clk,
  input  pfrt_pkg::cell_ctl_t         ctl,
  input  pfrt_pkg::lookup_key_t       key,
  input  logic                        new_dir,
  input  logic [pfrt_pkg::PORT_W-1:0] new_port,
  input  logic                        nbr_dir,
  input  logic [pfrt_pkg::PORT_W-1:0] nbr_port,
  output logic                        dir,
  output logic [pfrt_pkg::PORT_W-1:0] port,
  output logic                        hit
);

  logic                        dir_r,  dir_nxt;
  logic [pfrt_pkg::PORT_W-1:0] port_r, port_nxt;
  logic                        hit_r,  hit_nxt;

  always_comb begin
    dir_nxt  = dir_r;
    port_nxt = port_r;
    if (ctl.load) begin
      dir_nxt  = new_dir;
      port_nxt = new_port;
    end else if (ctl.shift) begin
      dir_nxt  = nbr_dir;
      port_nxt = nbr_port;
    end
    hit_nxt = key.chk && ctl.occ && (dir_r == key.dir) && (port_r == key.port);
  end

  always_ff @(posedge clk) begin
    dir_r  <= dir_nxt;
    port_r <= port_nxt;
    hit_r  <= hit_nxt;
  end

  assign dir  = dir_r;
  assign port = port_r;
  assign hit  = hit_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the port filter rule table: table scoreboard, drivers, monitor.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 100000;
  localparam int BLOCK_WORDS  = 60;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  typedef struct packed {
    logic                           drop;
    logic [pfrt_pkg::STATUS_W-1:0]  status;
    logic [pfrt_pkg::OUT_CNT_W-1:0] count;
  } verdict_t;

  // Mirrors the rule table and holds the verdicts still owed by the block.
  class rule_table_scoreboard;
    logic                        held_dir [pfrt_pkg::MAX_RULES_DEF];
    logic [pfrt_pkg::PORT_W-1:0] held_port [pfrt_pkg::MAX_RULES_DEF];
    int                          held_count;
    verdict_t                    owed_q[$];
    int                          errors;

    function new();
      held_count = 0;
      errors     = 0;
      foreach (held_dir[k]) begin
        held_dir[k]  = pfrt_pkg::DIR_IN;
        held_port[k] = '0;
      end
    endfunction

    function bit rule_hit(logic dir, logic [pfrt_pkg::PORT_W-1:0] port);
      for (int k = 0; k < held_count; k++) begin
        if (held_dir[k] == dir && held_port[k] == port) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: MISMATCH %s", $time, msg);
    endfunction

    function void note_word(logic [pfrt_pkg::CMD_W-1:0] cmd, logic rdir,
                            logic [pfrt_pkg::PORT_W-1:0] rport,
                            logic [pfrt_pkg::DEL_IDX_W-1:0] idx,
                            logic [pfrt_pkg::PORT_W-1:0] sport,
                            logic [pfrt_pkg::PORT_W-1:0] dport);
      verdict_t v;
      v = '0;
      v.status = pfrt_pkg::ST_OK;
      case (cmd)
        pfrt_pkg::CMD_ADD: begin
          if (held_count >= pfrt_pkg::MAX_RULES_DEF) begin
            v.status = pfrt_pkg::ST_FULL;
          end else begin
            held_dir[held_count]  = rdir;
            held_port[held_count] = rport;
            held_count++;
          end
        end
        pfrt_pkg::CMD_DEL: begin
          if (int'(idx) >= held_count) begin
            v.status = pfrt_pkg::ST_RANGE;
          end else begin
            // younger rules slide down one slot
            for (int k = int'(idx); k < held_count - 1; k++) begin
              held_dir[k]  = held_dir[k+1];
              held_port[k] = held_port[k+1];
            end
            held_count--;
          end
        end
        pfrt_pkg::CMD_INBOUND: v.drop = rule_hit(pfrt_pkg::DIR_IN, sport);
        default:               v.drop = rule_hit(pfrt_pkg::DIR_OUT, dport);
      endcase
      v.count = pfrt_pkg::OUT_CNT_W'(held_count);
      owed_q.push_back(v);
    endfunction

    function void check_word(logic drop, logic [pfrt_pkg::STATUS_W-1:0] status,
                             logic [pfrt_pkg::OUT_CNT_W-1:0] count);
      verdict_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected word drop=%0b status=%0d count=%0d",
                       drop, status, count));
        return;
      end
      want = owed_q.pop_front();
      if (want.drop !== drop || want.status !== status || want.count !== count)
        flag($sformatf("expected drop=%0b status=%0d count=%0d, got %0b %0d %0d",
                       want.drop, want.status, want.count, drop, status, count));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [pfrt_pkg::CMD_W-1:0]     in_cmd = pfrt_pkg::CMD_INBOUND;
  logic                           in_rule_dir = pfrt_pkg::DIR_IN;
  logic [pfrt_pkg::PORT_W-1:0]    in_rule_port = '0;
  logic [pfrt_pkg::DEL_IDX_W-1:0] in_del_index = '0;
  logic [pfrt_pkg::PORT_W-1:0]    in_src_port = '0;
  logic [pfrt_pkg::PORT_W-1:0]    in_dst_port = '0;
  logic                           out_valid;
  logic                           out_drop;
  logic [pfrt_pkg::STATUS_W-1:0]  out_status;
  logic [pfrt_pkg::OUT_CNT_W-1:0] out_count_now;

  rule_table_scoreboard sb = new();
  bit quiet_run = 1'b0;
  int cycles = 0;

  port_filter_rule_table DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_rule_dir  (in_rule_dir),
    .in_rule_port (in_rule_port),
    .in_del_index (in_del_index),
    .in_src_port  (in_src_port),
    .in_dst_port  (in_dst_port),
    .out_valid    (out_valid),
    .out_drop     (out_drop),
    .out_status   (out_status),
    .out_count_now(out_count_now)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result first: a word taken at this edge cannot have its result out yet
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_word(out_drop, out_status, out_count_now);
      if (start && busy === 1'b0)
        sb.note_word(in_cmd, in_rule_dir, in_rule_port, in_del_index, in_src_port,
                     in_dst_port);
    end
  end

  // fields the command does not use get random values
  task automatic send_word(input logic [pfrt_pkg::CMD_W-1:0] cmd, input logic rdir,
                           input logic [pfrt_pkg::PORT_W-1:0] key,
                           input logic [pfrt_pkg::DEL_IDX_W-1:0] idx);
    int r;
    int n;
    in_cmd       <= cmd;
    in_rule_dir  <= (cmd == pfrt_pkg::CMD_ADD) ? rdir : 1'($urandom);
    in_rule_port <= (cmd == pfrt_pkg::CMD_ADD) ? key : pfrt_pkg::PORT_W'($urandom);
    in_del_index <= (cmd == pfrt_pkg::CMD_DEL) ? idx : pfrt_pkg::DEL_IDX_W'($urandom);
    in_src_port  <= (cmd == pfrt_pkg::CMD_INBOUND) ? key : pfrt_pkg::PORT_W'($urandom);
    in_dst_port  <= (cmd == pfrt_pkg::CMD_OUTBOUND) ? key : pfrt_pkg::PORT_W'($urandom);
    start        <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (!quiet_run) begin
      r = $urandom_range(0, 99);
      if (r >= 50) begin
        n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        start <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [pfrt_pkg::PORT_W-1:0] pick_port();
    logic [pfrt_pkg::PORT_W-1:0] pool [8] = '{16'd22, 16'd80, 16'd443, 16'd8080,
                                              16'd53, 16'd1, 16'd32768, 16'd65534};
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return (r < 7) ? 16'd0 : 16'hFFFF;
    if (r < 55) return pool[$urandom_range(0, 7)];
    return pfrt_pkg::PORT_W'($urandom);
  endfunction

  task automatic random_word(input int mode);
    int r;
    int k;
    int add_pct;
    int del_pct;
    logic [pfrt_pkg::CMD_W-1:0]     cmd;
    logic [pfrt_pkg::PORT_W-1:0]    key;
    logic [pfrt_pkg::DEL_IDX_W-1:0] idx;
    case (mode)
      MODE_GROW:   begin add_pct = 70; del_pct = 5;  end
      MODE_SHRINK: begin add_pct = 10; del_pct = 50; end
      default:     begin add_pct = 30; del_pct = 25; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_pct) cmd = pfrt_pkg::CMD_ADD;
    else if (r < add_pct + del_pct) cmd = pfrt_pkg::CMD_DEL;
    else cmd = ($urandom_range(0, 1) == 0) ? pfrt_pkg::CMD_INBOUND : pfrt_pkg::CMD_OUTBOUND;
    key = pick_port();
    idx = pfrt_pkg::DEL_IDX_W'($urandom);
    if (cmd == pfrt_pkg::CMD_DEL && sb.held_count > 0 && $urandom_range(0, 99) < 85) begin
      r = $urandom_range(0, 9);
      if (r == 0) idx = '0;
      else if (r == 1) idx = pfrt_pkg::DEL_IDX_W'(sb.held_count - 1);
      else idx = pfrt_pkg::DEL_IDX_W'($urandom_range(0, sb.held_count - 1));
    end
    // aim most packets at a held rule so hits are common
    if ((cmd == pfrt_pkg::CMD_INBOUND || cmd == pfrt_pkg::CMD_OUTBOUND) &&
        sb.held_count > 0 && $urandom_range(0, 99) < 55) begin
      k = $urandom_range(0, sb.held_count - 1);
      cmd = (sb.held_dir[k] == pfrt_pkg::DIR_OUT) ? pfrt_pkg::CMD_OUTBOUND
                                                  : pfrt_pkg::CMD_INBOUND;
      key = sb.held_port[k];
    end
    send_word(cmd, 1'($urandom), key, idx);
  endtask

  initial begin
    int plan [11] = '{MODE_GROW, MODE_GROW, MODE_MIX, MODE_SHRINK, MODE_SHRINK, MODE_GROW,
                      MODE_GROW, MODE_MIX, MODE_SHRINK, MODE_GROW, MODE_MIX};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, port extremes, direction check, duplicates, deletes
    send_word(pfrt_pkg::CMD_DEL,      pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_OUT, 16'hFFFF, 6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_IN,  16'hFFFF, 6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_OUT, 16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'hFFFF, 6'd0);
    send_word(pfrt_pkg::CMD_OUTBOUND, pfrt_pkg::DIR_IN,  16'hFFFF, 6'd0);
    send_word(pfrt_pkg::CMD_OUTBOUND, pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd1,    6'd0);
    send_word(pfrt_pkg::CMD_OUTBOUND, pfrt_pkg::DIR_IN,  16'd443,  6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_OUT, 16'd443,  6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd443,  6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_IN,  16'd80,   6'd0);
    send_word(pfrt_pkg::CMD_ADD,      pfrt_pkg::DIR_IN,  16'd80,   6'd0);
    send_word(pfrt_pkg::CMD_DEL,      pfrt_pkg::DIR_IN,  16'd0,    6'd5);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd80,   6'd0);
    send_word(pfrt_pkg::CMD_DEL,      pfrt_pkg::DIR_IN,  16'd0,    6'd6);
    send_word(pfrt_pkg::CMD_DEL,      pfrt_pkg::DIR_IN,  16'd0,    6'd63);
    send_word(pfrt_pkg::CMD_DEL,      pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_INBOUND,  pfrt_pkg::DIR_IN,  16'd0,    6'd0);
    send_word(pfrt_pkg::CMD_OUTBOUND, pfrt_pkg::DIR_IN,  16'hFFFF, 6'd0);
    drain();

    // random blocks; grow phases run the table into full, every third has no gaps
    for (int b = 0; b < 11; b++) begin
      quiet_run = (b % 3 == 2);
      for (int i = 0; i < BLOCK_WORDS; i++) random_word(plan[b]);
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pfrt_pkg.sv
sv/pfrt_cell.sv
sv/port_filter_rule_table.sv
tb/tb_top.sv
